// File: hdl/pls_pkg.sv
package pls_pkg;

    // Default list depth
    localparam int DEPTH_DEF = 32;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_READ_OUT  = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Input word
    typedef struct packed {
        t_cmd                      command;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_in;

    // Output word
    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        logic                      last_of_run;
        t_status                   status;
        logic [CNT_W-1:0]          entry_count;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input word and execute it
        logic step;     // emit the next read-out entry
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;   // output register holds a word
        logic start_read;  // input word is a read out of a non-empty list
        logic rd_last;     // current read-out entry is the final one
    } t_dp_stat;

endpackage

// File: hdl/pls_ctrl.sv
module pls_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  pls_pkg::t_dp_stat  i_stat,
    output pls_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_ready
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   slot_free;

    // Output register can take a word this cycle
    assign slot_free = !i_stat.out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = slot_free;
                o_cmd.accept = i_in_valid && slot_free;
                if (o_cmd.accept && i_stat.start_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.step = slot_free;
                if (slot_free && i_stat.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/pls_dp.sv
module pls_dp #(
    parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pls_pkg::t_in      i_in_data,
    input  logic              i_out_ready,
    input  pls_pkg::t_dp_cmd  i_cmd,
    output pls_pkg::t_dp_stat o_stat,
    output pls_pkg::t_out     o_out_data,
    output logic              o_out_valid
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;

    logic signed [pls_pkg::VALUE_W-1:0] r_cells [DEPTH];
    logic signed [pls_pkg::VALUE_W-1:0] n_cells [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_rd_idx;
    pls_pkg::t_out    r_out;
    pls_pkg::t_out    n_out;
    logic             r_out_valid;

    logic             is_full;
    logic             is_empty;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             do_ins;
    logic             do_del;
    logic [CW-1:0]    op_idx;
    pls_pkg::t_status op_st;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign pos_x    = CMP_W'(i_in_data.position);
    assign cnt_x    = CMP_W'(r_count);

    // Status to controller
    assign o_stat.out_valid  = r_out_valid;
    assign o_stat.start_read = (i_in_data.command == pls_pkg::CMD_READ_OUT) && !is_empty;
    assign o_stat.rd_last    = ((r_rd_idx + CW'(1)) == r_count);

    // Command decode: checks and target index
    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        op_idx = '0;
        op_st  = pls_pkg::ST_OK;
        case (i_in_data.command)
            pls_pkg::CMD_INS_FRONT: begin
                if (is_full) op_st = pls_pkg::ST_FULL;
                else         do_ins = 1'b1;
            end
            pls_pkg::CMD_INS_BACK: begin
                op_idx = r_count;
                if (is_full) op_st = pls_pkg::ST_FULL;
                else         do_ins = 1'b1;
            end
            pls_pkg::CMD_INS_AT: begin
                op_idx = CW'(pos_x - CMP_W'(1));
                if (is_full) begin
                    op_st = pls_pkg::ST_FULL;
                end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                    op_st = pls_pkg::ST_RANGE;
                end else begin
                    do_ins = 1'b1;
                end
            end
            pls_pkg::CMD_DEL_FRONT: begin
                if (is_empty) op_st = pls_pkg::ST_EMPTY;
                else          do_del = 1'b1;
            end
            pls_pkg::CMD_DEL_BACK: begin
                op_idx = r_count - CW'(1);
                if (is_empty) op_st = pls_pkg::ST_EMPTY;
                else          do_del = 1'b1;
            end
            pls_pkg::CMD_DEL_AT: begin
                op_idx = CW'(pos_x - CMP_W'(1));
                if (is_empty) begin
                    op_st = pls_pkg::ST_EMPTY;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    op_st = pls_pkg::ST_RANGE;
                end else begin
                    do_del = 1'b1;
                end
            end
            pls_pkg::CMD_READ_OUT: begin
                if (is_empty) op_st = pls_pkg::ST_EMPTY;
            end
            default: begin
                op_st = pls_pkg::ST_OK;
            end
        endcase
    end

    // Cell row: parallel shift on insert/delete, rotate toward the front on read out
    always_comb begin
        n_cells = r_cells;
        n_count = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.accept && do_ins) begin
                if (CW'(i) == op_idx) begin
                    n_cells[i] = i_in_data.value;
                end else if (i > 0 && CW'(i) > op_idx && CW'(i) <= r_count) begin
                    n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.accept && do_del) begin
                if (i < DEPTH - 1 && CW'(i) >= op_idx && CW'(i + 1) < r_count) begin
                    n_cells[i] = r_cells[(i < DEPTH - 1) ? i + 1 : i];
                end
            end else if (i_cmd.step) begin
                if (CW'(i + 1) == r_count) begin
                    n_cells[i] = r_cells[0];
                end else if (i < DEPTH - 1 && CW'(i + 1) < r_count) begin
                    n_cells[i] = r_cells[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
        if (i_cmd.accept && do_ins) n_count = r_count + CW'(1);
        if (i_cmd.accept && do_del) n_count = r_count - CW'(1);
    end

    // Result word
    always_comb begin
        n_out = r_out;
        if (i_cmd.step) begin
            n_out.entry_value = r_cells[0];
            n_out.last_of_run = o_stat.rd_last;
            n_out.status      = pls_pkg::ST_OK;
            n_out.entry_count = pls_pkg::CNT_W'(r_count);
        end else if (i_cmd.accept) begin
            n_out.entry_value = '0;
            n_out.last_of_run = 1'b1;
            n_out.status      = op_st;
            n_out.entry_count = pls_pkg::CNT_W'(n_count);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        r_out   <= n_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.accept) begin
                r_rd_idx <= '0;
            end else if (i_cmd.step) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if ((i_cmd.accept && !o_stat.start_read) || i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/positional_list_store_core.sv
// Channel | Direction | Handshake               | Word
// in      | input     | i_in_valid / o_in_ready | pls_pkg::t_in  (command, value, position)
// out     | output    | o_out_valid / i_out_ready | pls_pkg::t_out (entry_value, last_of_run,
//         |           |                         |   status, entry_count)
//
// Insert, delete and unused commands, and read out of an empty list, give one word each;
// with the output taken every cycle a new command is accepted every cycle.
// Read out of a non-empty list is accepted without a word, then gives one word per stored
// entry, one per cycle while the output is taken, through a rotation of the cell row; no
// command is accepted until its final word is in the output register.
// Reset (synchronous, active low) empties the list; cell contents are not cleared.
// A stalled output holds its word and blocks the next command or read-out step.
module positional_list_store_core #(
    parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pls_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pls_pkg::t_out o_out_data
);

    pls_pkg::t_dp_cmd  dp_cmd;
    pls_pkg::t_dp_stat dp_stat;

    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .o_in_ready  (o_in_ready)
    );

    pls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid)
    );

endmodule

// File: test/positional_list_store_checker.sv
`timescale 1ns / 100ps

module positional_list_store_checker #(
    parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  pls_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  pls_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);

    // Shadow copy of the list, front at index 0
    logic signed [pls_pkg::VALUE_W-1:0] list_cells [DEPTH];
    int                                 list_len = 0;

    // Words still owed by the block, oldest first
    pls_pkg::t_out expected_words [$];
    int            mismatches = 0;

    // Shift the tail up one place and drop the new value in at idx
    function automatic pls_pkg::t_status insert_entry(
        input int                                 idx,
        input logic signed [pls_pkg::VALUE_W-1:0] v
    );
        if (list_len >= DEPTH) begin
            return pls_pkg::ST_FULL;
        end
        if (idx > list_len) begin
            return pls_pkg::ST_RANGE;
        end
        for (int i = list_len; i > idx; i--) begin
            list_cells[i] = list_cells[i-1];
        end
        list_cells[idx] = v;
        list_len++;
        return pls_pkg::ST_OK;
    endfunction

    // Close the gap left by the entry at idx
    function automatic pls_pkg::t_status delete_entry(input int idx);
        if (list_len == 0) begin
            return pls_pkg::ST_EMPTY;
        end
        if (idx >= list_len) begin
            return pls_pkg::ST_RANGE;
        end
        for (int i = idx; i + 1 < list_len; i++) begin
            list_cells[i] = list_cells[i+1];
        end
        list_len--;
        return pls_pkg::ST_OK;
    endfunction

    // Apply one command to the shadow list and queue the words it produces
    task automatic predict_words(input pls_pkg::t_in w);
        pls_pkg::t_status st;
        pls_pkg::t_out    word;
        int               p;
        st = pls_pkg::ST_OK;
        p  = int'(w.position);
        case (w.command)
            pls_pkg::CMD_INS_FRONT: st = insert_entry(0, w.value);
            pls_pkg::CMD_INS_BACK:  st = insert_entry(list_len, w.value);
            pls_pkg::CMD_INS_AT: begin
                if (p == 0) begin
                    st = (list_len >= DEPTH) ? pls_pkg::ST_FULL : pls_pkg::ST_RANGE;
                end else begin
                    st = insert_entry(p - 1, w.value);
                end
            end
            pls_pkg::CMD_DEL_FRONT: st = delete_entry(0);
            pls_pkg::CMD_DEL_BACK: begin
                st = (list_len == 0) ? pls_pkg::ST_EMPTY : delete_entry(list_len - 1);
            end
            pls_pkg::CMD_DEL_AT: begin
                if (p == 0) begin
                    st = (list_len == 0) ? pls_pkg::ST_EMPTY : pls_pkg::ST_RANGE;
                end else begin
                    st = delete_entry(p - 1);
                end
            end
            pls_pkg::CMD_READ_OUT: begin
                if (list_len == 0) begin
                    st = pls_pkg::ST_EMPTY;
                end
            end
            default: st = pls_pkg::ST_OK;
        endcase

        if (w.command == pls_pkg::CMD_READ_OUT && list_len != 0) begin
            // one word per entry, front to back
            for (int i = 0; i < list_len; i++) begin
                word.entry_value = list_cells[i];
                word.last_of_run = (i == list_len - 1);
                word.status      = pls_pkg::ST_OK;
                word.entry_count = pls_pkg::CNT_W'(list_len);
                expected_words.push_back(word);
            end
        end else begin
            word.entry_value = '0;
            word.last_of_run = 1'b1;
            word.status      = st;
            word.entry_count = pls_pkg::CNT_W'(list_len);
            expected_words.push_back(word);
        end
    endtask

    // Compare a delivered word against the oldest prediction
    task automatic check_word(input pls_pkg::t_out got);
        pls_pkg::t_out want;
        if (expected_words.size() == 0) begin
            $error("unexpected word: entry_value %0d status %0d entry_count %0d",
                   got.entry_value, got.status, got.entry_count);
            mismatches++;
        end else begin
            want = expected_words.pop_front();
            if (got.entry_value !== want.entry_value) begin
                $error("entry_value: expected %0d, actual %0d",
                       want.entry_value, got.entry_value);
                mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, actual %0d",
                       want.last_of_run, got.last_of_run);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                mismatches++;
            end
        end
    endtask

    // Watch both channels; output first, its prediction is already queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_word(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict_words(i_in_data);
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: test/positional_list_store_core_tb.sv
`timescale 1ns / 100ps

module positional_list_store_core_tb;

    localparam int LIST_DEPTH = pls_pkg::DEPTH_DEF;
    // Longest stretch without any handshake before the run is called hung
    localparam int HANG_LIMIT = 2000;
    // Code outside the defined command set
    localparam logic [pls_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
    // Command mix per phase: share of inserts in percent
    localparam int MIX_GROW   = 85;
    localparam int MIX_EVEN   = 50;
    localparam int MIX_SHRINK = 15;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_ready;
    pls_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_ready = 1'b1;
    pls_pkg::t_out out_data;

    int    fail_count;
    int    pending_words;
    logic  quiet;
    int    stall_left  = 0;
    int    idle_cycles = 0;

    positional_list_store_core #(
        .DEPTH (LIST_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    positional_list_store_checker #(
        .DEPTH (LIST_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Output side: ready drops in bursts of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ready = 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_ready  = 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            out_ready = 1'b1;
        end
    end

    // Hang detection: no word moving on either channel for too long
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic pls_pkg::t_in make_word(
        input logic [pls_pkg::CMD_W-1:0]          cmd,
        input logic signed [pls_pkg::VALUE_W-1:0] v,
        input logic [pls_pkg::POS_W-1:0]          p
    );
        pls_pkg::t_in w;
        w.command  = pls_pkg::t_cmd'(cmd);
        w.value    = v;
        w.position = p;
        return w;
    endfunction

    // Random command; insert_pct steers the list toward full or empty
    function automatic pls_pkg::t_in random_word(input int insert_pct);
        int                                 r;
        logic [pls_pkg::CMD_W-1:0]          cmd;
        logic signed [pls_pkg::VALUE_W-1:0] v;
        logic [pls_pkg::POS_W-1:0]          p;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            cmd = pls_pkg::CMD_READ_OUT;
        end else if (r < 10) begin
            cmd = CMD_UNUSED;
        end else if ($urandom_range(0, 99) < insert_pct) begin
            case ($urandom_range(0, 2))
                0:       cmd = pls_pkg::CMD_INS_FRONT;
                1:       cmd = pls_pkg::CMD_INS_BACK;
                default: cmd = pls_pkg::CMD_INS_AT;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       cmd = pls_pkg::CMD_DEL_FRONT;
                1:       cmd = pls_pkg::CMD_DEL_BACK;
                default: cmd = pls_pkg::CMD_DEL_AT;
            endcase
        end
        case ($urandom_range(0, 9))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = 32'sd0;
            3:       v = -32'sd1;
            default: v = $urandom;
        endcase
        // mostly near the legal range, sometimes anywhere in the field
        p = ($urandom_range(0, 3) == 0)
            ? pls_pkg::POS_W'($urandom_range(0, 63))
            : pls_pkg::POS_W'($urandom_range(0, LIST_DEPTH + 2));
        return make_word(cmd, v, p);
    endfunction

    // Present one word, with an optional gap first, and hold it until taken
    task automatic send_word(input pls_pkg::t_in w);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic run_phase(input int n, input int insert_pct);
        for (int i = 0; i < n; i++) begin
            send_word(random_word(insert_pct));
        end
    endtask

    initial begin
        in_valid    = 1'b0;
        in_data     = '0;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list corner cases
        send_word(make_word(pls_pkg::CMD_READ_OUT,  32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_DEL_FRONT, 32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_DEL_BACK,  32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_DEL_AT,    32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_DEL_AT,    32'sd0, 6'd1));
        send_word(make_word(pls_pkg::CMD_INS_AT,    32'sd5, 6'd0));
        send_word(make_word(pls_pkg::CMD_INS_AT,    32'sd5, 6'd2));
        // Build a short list with extreme values; position 1 goes to the front
        send_word(make_word(pls_pkg::CMD_INS_AT,    32'sh7FFF_FFFF, 6'd1));
        send_word(make_word(pls_pkg::CMD_INS_FRONT, 32'sh8000_0000, 6'd0));
        send_word(make_word(pls_pkg::CMD_INS_BACK,  -32'sd1, 6'd0));
        send_word(make_word(pls_pkg::CMD_INS_AT,    32'sd0, 6'd4));
        send_word(make_word(pls_pkg::CMD_INS_AT,    32'sh5555_5555, 6'd2));
        send_word(make_word(pls_pkg::CMD_READ_OUT,  32'sd0, 6'd0));
        // Position checks on a list of five
        send_word(make_word(pls_pkg::CMD_DEL_AT,    32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_DEL_AT,    32'sd0, 6'd6));
        send_word(make_word(pls_pkg::CMD_DEL_AT,    32'sd0, 6'd5));
        send_word(make_word(pls_pkg::CMD_DEL_AT,    32'sd0, 6'd2));
        send_word(make_word(CMD_UNUSED,             32'shAAAA_AAAA, 6'h3F));
        send_word(make_word(pls_pkg::CMD_DEL_FRONT, 32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_DEL_BACK,  32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_READ_OUT,  32'sd0, 6'd0));
        // Last entry removed from the back
        send_word(make_word(pls_pkg::CMD_DEL_BACK,  32'sd0, 6'd0));
        send_word(make_word(pls_pkg::CMD_INS_AT,    32'sd9, 6'd63));
        send_word(make_word(pls_pkg::CMD_READ_OUT,  32'sd0, 6'd0));

        // Random phases sweep the list between empty and full
        run_phase(60, MIX_GROW);
        run_phase(50, MIX_EVEN);
        run_phase(60, MIX_SHRINK);
        run_phase(60, MIX_GROW);
        run_phase(40, MIX_EVEN);
        run_phase(40, MIX_SHRINK);
        // Final stretch at full rate on both sides
        quiet = 1'b1;
        run_phase(40, MIX_GROW);

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_words != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
